@@ design/mlft_pkg.sv @@
// Package with the table geometry, action codes and transaction payload types.
package mlft_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int MAC_W = 48;
	localparam int PORT_W = 16;
	localparam int BUF_W = 32;
	localparam int COOKIE_W = 64;
	localparam int ACT_W = 2;

	localparam logic [BUF_W-1:0] NO_BUFFER = {BUF_W{1'b1}};

	localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FLOOD_BUFFERED = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FLOOD_CARRIED = 2'd2;

	typedef struct packed {
		logic [MAC_W-1:0]  source_mac;
		logic [MAC_W-1:0]  dest_mac;
		logic [PORT_W-1:0] ingress_port;
		logic [BUF_W-1:0]  buffer_ref;
	} frame_req_t;

	typedef struct packed {
		logic [ACT_W-1:0]    action;
		logic [PORT_W-1:0]   egress_port;
		logic [COOKIE_W-1:0] flow_cookie;
		logic [BUF_W-1:0]    buffer_echo;
		logic [PORT_W-1:0]   port_echo;
	} frame_rsp_t;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} entry_t;

endpackage

@@ design/mlft_ifs.sv @@
// Valid/ready channel interfaces for frame requests and forwarding decisions.
interface mlft_req_if;
	logic                 valid;
	logic                 ready;
	mlft_pkg::frame_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mlft_rsp_if;
	logic                 valid;
	logic                 ready;
	mlft_pkg::frame_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/mac_learning_forwarding_table.sv @@
// Each frame is accepted and then scanned: the single-port table memory is read one
// entry a cycle, and each entry is compared against both the source and destination
// MAC, followed by a write-back of the learned entry, in which the decision is
// registered. A new frame is taken in the cycle after that write-back, even while
// the previous decision waits on the output, so a frame is not accepted until the
// scan and write-back of the previous one are through. The write-back waits while
// an earlier decision is still held on the output. Entry valid bits are flip-flops
// cleared by reset, so no clearing pass is needed. A full table replaces entries
// round-robin.
module mac_learning_forwarding_table (
	input  logic              clk,
	input  logic              arst_n,
	mlft_req_if.sink          req,
	mlft_rsp_if.source        rsp
);
	import mlft_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	entry_t mem [TABLE_ENTRIES];

	logic [1:0]                 state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [TABLE_ENTRIES-1:0]   valid_q;
	logic [IDX_W-1:0]           rp_q;
	logic [COOKIE_W-1:0]        cookie_q;
	frame_req_t                 item_q;

	logic                       rd_en;
	logic [IDX_W-1:0]           rd_idx;
	logic                       rd_vld_s1;
	logic [IDX_W-1:0]           rd_idx_s1;
	entry_t                     rd_data_s1;

	logic                       src_hit_q;
	logic [IDX_W-1:0]           src_idx_q;
	logic                       free_found_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic                       dst_hit_q;
	logic [IDX_W-1:0]           dst_idx_q;
	logic [PORT_W-1:0]          dst_port_q;

	logic                       rsp_valid_q;
	frame_rsp_t                 rsp_q;

	logic                       wr_go;
	logic [IDX_W-1:0]           slot;
	logic                       fwd;
	logic [PORT_W-1:0]          fwd_port;
	logic                       ent_valid;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	assign rd_idx = cnt_q[IDX_W-1:0];
	assign rd_en = (state_q == ST_SCAN) && (cnt_q != CNT_END);
	assign ent_valid = valid_q[rd_idx_s1];
	assign wr_go = (state_q == ST_WRITE) && (!rsp_valid_q || rsp.ready);

	// The learned slot is known only after the full scan. A destination found in
	// the slot being replaced no longer exists once the source is written there.
	always_comb begin
		priority if (src_hit_q) begin
			slot = src_idx_q;
		end else if (free_found_q) begin
			slot = free_idx_q;
		end else begin
			slot = rp_q;
		end
		fwd = 1'b0;
		fwd_port = '0;
		priority if (item_q.dest_mac == item_q.source_mac) begin
			fwd = 1'b1;
			fwd_port = item_q.ingress_port;
		end else if (dst_hit_q && (dst_idx_q != slot)) begin
			fwd = 1'b1;
			fwd_port = dst_port_q;
		end
	end

	// Reads and the write-back never fall in the same cycle, so no forwarding
	// between them is needed.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx];
		end
		if (wr_go) begin
			mem[slot] <= '{mac: item_q.source_mac, port: item_q.ingress_port};
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_q <= req.data;
		end
		rd_idx_s1 <= rd_idx;
		if (rd_vld_s1) begin
			if (ent_valid && (rd_data_s1.mac == item_q.source_mac)) begin
				src_idx_q <= rd_idx_s1;
			end
			if (!ent_valid && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (ent_valid && (rd_data_s1.mac == item_q.dest_mac)) begin
				dst_idx_q <= rd_idx_s1;
				dst_port_q <= rd_data_s1.port;
			end
		end
		if (wr_go) begin
			rsp_q.egress_port <= fwd_port;
			rsp_q.flow_cookie <= fwd ? cookie_q : '0;
			rsp_q.buffer_echo <= item_q.buffer_ref;
			rsp_q.port_echo <= item_q.ingress_port;
			if (fwd) begin
				rsp_q.action <= ACT_FORWARD;
			end else if (item_q.buffer_ref == NO_BUFFER) begin
				rsp_q.action <= ACT_FLOOD_CARRIED;
			end else begin
				rsp_q.action <= ACT_FLOOD_BUFFERED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			valid_q <= '0;
			rp_q <= '0;
			cookie_q <= '0;
			rd_vld_s1 <= 1'b0;
			src_hit_q <= 1'b0;
			free_found_q <= 1'b0;
			dst_hit_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_vld_s1) begin
				if (ent_valid && (rd_data_s1.mac == item_q.source_mac)) begin
					src_hit_q <= 1'b1;
				end
				if (!ent_valid) begin
					free_found_q <= 1'b1;
				end
				if (ent_valid && (rd_data_s1.mac == item_q.dest_mac)) begin
					dst_hit_q <= 1'b1;
				end
			end
			if (rsp.ready && rsp_valid_q && !wr_go) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_SCAN;
						cnt_q <= '0;
						src_hit_q <= 1'b0;
						free_found_q <= 1'b0;
						dst_hit_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CNT_END) begin
						state_q <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRITE: begin
					if (wr_go) begin
						valid_q[slot] <= 1'b1;
						if (!src_hit_q && !free_found_q) begin
							rp_q <= (rp_q == IDX_LAST) ? '0 : rp_q + 1'b1;
						end
						if (fwd) begin
							cookie_q <= cookie_q + 1'b1;
						end
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
